// ===== src/mbq_pkg.sv =====
`timescale 1ns / 1ps

package mbq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_DECREASE = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   // Where the unlink sequence continues when it is done.
   typedef enum logic [1:0] {
      RET_PLACE,
      RET_EXTRACT,
      RET_REDIST
   } ret_type;

endpackage

// ===== src/mbq_ram.sv =====
`timescale 1ns / 1ps

module mbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/multilevel_bucket_queue_decrease_key.sv =====
`timescale 1ns / 1ps
// Monotone multi-level bucket priority queue with decrease-key.
// A command beat is taken when start is high and busy is low; req_op selects
// insert, extract minimum, decrease key or clear. busy stays high until the
// command is finished, and exactly one result beat follows each command:
// rsp_done is high for one cycle with the rsp_ fields valid in that cycle.
// The receiver cannot stall; a result is gone after its one cycle.
// Steps from the accepting edge to the result beat: an insert reads the
// vertex's node words, unlinks it if it is queued and links it into its new
// bucket, with an extra tail fetch when it appends to a nonempty bucket.
// Extract scans the lowest level bucket by bucket (an empty queue answers with
// underflow straight away); when that level runs dry, it scans the upper level
// and moves its vertices down one by one. Clear sweeps the vertex marks. The
// node and bucket memories have registered reads, which every link step goes
// through in turn. After reset the block sweeps the vertex marks with busy
// high and gives no result for that sweep. An out-of-range vertex on insert
// or decrease key is ignored.
module multilevel_bucket_queue_decrease_key #(
   parameter int LEVELS     = 4,
   parameter int DIGIT_BITS = 4,
   parameter int NODES      = 1024,
   parameter int KEY_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_vertex,
   input  logic [31:0] req_key,
   output logic        rsp_done,
   output logic [9:0]  rsp_min_vertex,
   output logic [31:0] rsp_min_key,
   output logic        rsp_is_empty,
   output logic        rsp_underflow
);

   localparam int DB  = DIGIT_BITS;
   localparam int NB  = 1 << DIGIT_BITS;
   localparam int NBT = LEVELS * NB;
   localparam int LW  = $clog2(LEVELS);
   localparam int SW  = LW + DB;
   localparam int LQW = $clog2(LEVELS + 1);
   localparam int ABW = DB + 1;
   localparam int NW  = DB + 1;
   localparam int VW  = $clog2(NODES);
   localparam int CW  = $clog2(NODES + 1);
   localparam int KW  = KEY_BITS;
   localparam int LBW = LQW + DB;
   localparam logic [LW-1:0]  BOT = LW'(LEVELS - 1);
   localparam logic [LBW-1:0] NOT_QUEUED = {LQW'(LEVELS), DB'(0)};

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_U0, S_U1, S_U2, S_PLACE, S_PUSH, S_PUSH_LINK,
      S_SCAN_BOT, S_FIND_AUX, S_SCAN_AUX, S_RD_LVL, S_RD_CHK, S_RD_HEAD,
      S_RD_MOVE, S_FINISH, S_EX_HEAD, S_EX_V, S_EX_DONE
   } state_type;

   function automatic logic [DB-1:0] digit_f(input logic [KW-1:0] k, input int l);
      int sh;
      sh = DB * (LEVELS - 1 - l);
      return DB'(k >> sh);
   endfunction

   state_type            state_ff, state_in;
   mbq_pkg::ret_type     ret_ff, ret_in;
   logic [VW-1:0]        v_ff, v_in, nxt_ff, nxt_in, prv_ff, prv_in, clr_ff, clr_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [LW-1:0]        lvl_ff, lvl_in, ulvl_ff, ulvl_in, aux_ff, aux_in, i_ff, i_in;
   logic [DB-1:0]        bkt_ff, bkt_in, ubkt_ff, ubkt_in, auxb_ff, auxb_in;
   logic [NW-1:0]        scan_ff, scan_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [NBT-1:0]       ne_ff, ne_in;
   logic [ABW-1:0]       act_ff [LEVELS];
   logic [ABW-1:0]       act_in [LEVELS];
   logic [CW-1:0]        lcnt_ff [LEVELS];
   logic [CW-1:0]        lcnt_in [LEVELS];
   logic [CW-1:0]        total_ff, total_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic [9:0]           rsp_mv_ff, rsp_mv_in;
   logic [31:0]          rsp_mk_ff, rsp_mk_in;
   logic                 rsp_empty_ff, rsp_empty_in, rsp_uf_ff, rsp_uf_in;

   // Memory ports.
   logic                 key_we, lb_we, nx_we, pv_we, hd_we, tl_we;
   logic [VW-1:0]        lb_wa, nx_wa, pv_wa, nx_wd, pv_wd, hd_wd, tl_wd;
   logic [LBW-1:0]       lb_wd, lb_rd;
   logic [SW-1:0]        hd_wa, tl_wa, bk_ra;
   logic [KW-1:0]        key_rd;
   logic [VW-1:0]        nx_rd, pv_rd, hd_rd, tl_rd;

   mbq_ram #(.WIDTH(KW), .DEPTH(NODES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(v_ff), .wr_data(k_ff),
      .rd_addr(v_ff), .rd_data(key_rd));
   mbq_ram #(.WIDTH(LBW), .DEPTH(NODES)) u_lb_ram (
      .clock(clock), .wr_en(lb_we), .wr_addr(lb_wa), .wr_data(lb_wd),
      .rd_addr(v_ff), .rd_data(lb_rd));
   mbq_ram #(.WIDTH(VW), .DEPTH(NODES)) u_next_ram (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(v_ff), .rd_data(nx_rd));
   mbq_ram #(.WIDTH(VW), .DEPTH(NODES)) u_prev_ram (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_addr(v_ff), .rd_data(pv_rd));
   mbq_ram #(.WIDTH(VW), .DEPTH(NBT)) u_head_ram (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(bk_ra), .rd_data(hd_rd));
   mbq_ram #(.WIDTH(VW), .DEPTH(NBT)) u_tail_ram (
      .clock(clock), .wr_en(tl_we), .wr_addr(tl_wa), .wr_data(tl_wd),
      .rd_addr(bk_ra), .rd_data(tl_rd));

   always_comb begin
      logic          found, emit, emit_uf;
      logic [LW-1:0] plvl, ip1;
      logic [DB-1:0] pbkt, d1, d2, dm;
      logic [SW-1:0] s_push, s_ul, s_rd;
      logic          is_head, is_tail;

      state_in = state_ff;  ret_in = ret_ff;  v_in = v_ff;  k_in = k_ff;
      nxt_in = nxt_ff;  prv_in = prv_ff;  clr_in = clr_ff;  clr_rsp_in = clr_rsp_ff;
      lvl_in = lvl_ff;  bkt_in = bkt_ff;  ulvl_in = ulvl_ff;  ubkt_in = ubkt_ff;
      aux_in = aux_ff;  auxb_in = auxb_ff;  i_in = i_ff;  scan_in = scan_ff;
      ne_in = ne_ff;  act_in = act_ff;  lcnt_in = lcnt_ff;  total_in = total_ff;
      emit = 1'b0;  emit_uf = 1'b0;

      key_we = 1'b0;  lb_we = 1'b0;  nx_we = 1'b0;  pv_we = 1'b0;
      hd_we = 1'b0;  tl_we = 1'b0;
      lb_wa = v_ff;  lb_wd = NOT_QUEUED;
      nx_wa = v_ff;  nx_wd = v_ff;  pv_wa = v_ff;  pv_wd = v_ff;
      hd_wd = v_ff;  tl_wd = v_ff;

      // Target level and bucket of the key being placed.
      found = 1'b0;  plvl = '0;  pbkt = '0;
      for (int i = 0; i < LEVELS - 2; i++) begin
         if (!found && ABW'(digit_f(k_ff, i)) != act_ff[i]) begin
            found = 1'b1;
            plvl  = LW'(i);
            pbkt  = digit_f(k_ff, i);
         end
      end
      d2 = digit_f(k_ff, LEVELS - 2);
      d1 = digit_f(k_ff, LEVELS - 1);
      if (!found) begin
         if (ABW'(d2) != act_ff[LEVELS-2] || ABW'(d1) < act_ff[LEVELS-1]) begin
            plvl = LW'(LEVELS - 2);
            pbkt = d2;
         end else begin
            plvl = BOT;
            pbkt = d1;
         end
      end

      ip1    = i_ff + 1'b1;
      dm     = digit_f(k_ff, int'(ip1));
      s_push = {lvl_ff, bkt_ff};
      s_ul   = {ulvl_ff, ubkt_ff};
      s_rd   = {i_ff, act_ff[i_ff][DB-1:0]};
      hd_wa  = s_push;
      tl_wa  = s_push;
      bk_ra  = s_push;
      is_head = hd_rd == v_ff;
      is_tail = tl_rd == v_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (mbq_pkg::op_type'(req_op))
                  mbq_pkg::OP_INSERT, mbq_pkg::OP_DECREASE: begin
                     v_in   = VW'(req_vertex);
                     k_in   = KW'(req_key);
                     ret_in = mbq_pkg::RET_PLACE;
                     if (32'(req_vertex) < 32'(NODES)) begin
                        state_in = S_U0;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  mbq_pkg::OP_EXTRACT: begin
                     if (total_ff == '0) begin
                        emit    = 1'b1;
                        emit_uf = 1'b1;
                     end else begin
                        state_in = S_SCAN_BOT;
                     end
                  end
                  mbq_pkg::OP_CLEAR: begin
                     ne_in      = '0;
                     total_in   = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     for (int i = 0; i < LEVELS; i++) begin
                        act_in[i]  = '0;
                        lcnt_in[i] = '0;
                     end
                     state_in = S_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            lb_we = 1'b1;
            lb_wa = clr_ff;
            if (clr_ff == VW'(NODES - 1)) begin
               emit     = clr_rsp_ff;
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_U0: state_in = S_U1;
         S_U1: begin
            nxt_in  = nx_rd;
            prv_in  = pv_rd;
            ulvl_in = LW'(lb_rd[LBW-1:DB]);
            ubkt_in = lb_rd[DB-1:0];
            bk_ra   = {LW'(lb_rd[LBW-1:DB]), lb_rd[DB-1:0]};
            if (ret_ff != mbq_pkg::RET_PLACE) begin
               k_in = key_rd;
            end
            if (ret_ff == mbq_pkg::RET_PLACE && lb_rd[LBW-1:DB] >= LQW'(LEVELS)) begin
               total_in = total_ff + 1'b1;
               state_in = S_PLACE;
            end else begin
               state_in = S_U2;
            end
         end
         S_U2: begin
            hd_wa = s_ul;
            tl_wa = s_ul;
            if (is_head && is_tail) begin
               ne_in[s_ul] = 1'b0;
            end else if (is_head) begin
               hd_we = 1'b1;
               hd_wd = nxt_ff;
            end else if (is_tail) begin
               tl_we = 1'b1;
               tl_wd = prv_ff;
            end else begin
               nx_we = 1'b1;  nx_wa = prv_ff;  nx_wd = nxt_ff;
               pv_we = 1'b1;  pv_wa = nxt_ff;  pv_wd = prv_ff;
            end
            lcnt_in[ulvl_ff] = lcnt_ff[ulvl_ff] - 1'b1;
            lb_we = 1'b1;
            case (ret_ff)
               mbq_pkg::RET_PLACE:   state_in = S_PLACE;
               mbq_pkg::RET_EXTRACT: state_in = S_EX_DONE;
               default:              state_in = S_RD_MOVE;
            endcase
         end
         S_PLACE: begin
            key_we   = 1'b1;
            lvl_in   = plvl;
            bkt_in   = pbkt;
            state_in = S_PUSH;
         end
         S_PUSH, S_PUSH_LINK: begin
            if (state_ff == S_PUSH && ne_ff[s_push]) begin
               // Append to a nonempty bucket: fetch its tail first.
               state_in = S_PUSH_LINK;
            end else begin
               if (state_ff == S_PUSH_LINK) begin
                  nx_we = 1'b1;  nx_wa = tl_rd;  nx_wd = v_ff;
                  pv_we = 1'b1;  pv_wa = v_ff;   pv_wd = tl_rd;
               end else begin
                  hd_we = 1'b1;
               end
               tl_we = 1'b1;
               ne_in[s_push] = 1'b1;
               lb_we = 1'b1;
               lb_wd = {LQW'(lvl_ff), bkt_ff};
               lcnt_in[lvl_ff] = lcnt_ff[lvl_ff] + 1'b1;
               if (ret_ff == mbq_pkg::RET_REDIST) begin
                  state_in = S_RD_CHK;
               end else begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN_BOT: begin
            if (act_ff[BOT] < ABW'(NB)) begin
               if (ne_ff[{BOT, act_ff[BOT][DB-1:0]}]) begin
                  state_in = S_EX_HEAD;
               end else begin
                  act_in[BOT] = act_ff[BOT] + 1'b1;
               end
            end else begin
               state_in = S_FIND_AUX;
            end
         end
         S_FIND_AUX: begin
            found = 1'b0;
            for (int i = 0; i < LEVELS - 1; i++) begin
               if (lcnt_ff[i] != '0) begin
                  found  = 1'b1;
                  aux_in = LW'(i);
               end
            end
            if (found) begin
               auxb_in  = (act_ff[aux_in] >= ABW'(NB)) ? '0 : act_ff[aux_in][DB-1:0];
               scan_in  = '0;
               state_in = S_SCAN_AUX;
            end else begin
               emit     = 1'b1;
               emit_uf  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN_AUX: begin
            if (scan_ff == NW'(NB)) begin
               emit     = 1'b1;
               emit_uf  = 1'b1;
               state_in = S_IDLE;
            end else if (ne_ff[{aux_ff, auxb_ff}]) begin
               act_in[aux_ff] = ABW'(auxb_ff);
               i_in     = aux_ff;
               state_in = S_RD_LVL;
            end else begin
               auxb_in = auxb_ff + 1'b1;
               scan_in = scan_ff + 1'b1;
            end
         end
         S_RD_LVL: begin
            act_in[ip1] = ABW'(NB);
            state_in    = S_RD_CHK;
         end
         S_RD_CHK: begin
            bk_ra = s_rd;
            if (ne_ff[s_rd]) begin
               state_in = S_RD_HEAD;
            end else if (32'(i_ff) + 32'd2 < 32'(LEVELS)) begin
               i_in     = ip1;
               state_in = S_RD_LVL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RD_HEAD: begin
            v_in     = hd_rd;
            ret_in   = mbq_pkg::RET_REDIST;
            state_in = S_U0;
         end
         S_RD_MOVE: begin
            lvl_in = ip1;
            bkt_in = dm;
            if (ABW'(dm) < act_ff[ip1]) begin
               act_in[ip1] = ABW'(dm);
            end
            state_in = S_PUSH;
         end
         S_FINISH: begin
            if (act_ff[BOT] < ABW'(NB)) begin
               state_in = S_EX_HEAD;
            end else begin
               emit     = 1'b1;
               emit_uf  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EX_HEAD: begin
            bk_ra    = {BOT, act_ff[BOT][DB-1:0]};
            state_in = S_EX_V;
         end
         S_EX_V: begin
            v_in     = hd_rd;
            ret_in   = mbq_pkg::RET_EXTRACT;
            state_in = S_U0;
         end
         S_EX_DONE: begin
            total_in = total_ff - 1'b1;
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         state_in = S_IDLE;
      end
      rsp_done_in  = emit;
      rsp_uf_in    = emit_uf;
      rsp_empty_in = total_in == '0;
      rsp_mv_in    = (state_ff == S_EX_DONE) ? 10'(v_ff) : '0;
      rsp_mk_in    = (state_ff == S_EX_DONE) ? 32'(k_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         clr_rsp_ff  <= 1'b0;
         ne_ff       <= '0;
         total_ff    <= '0;
         rsp_done_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            act_ff[i]  <= '0;
            lcnt_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_rsp_ff  <= clr_rsp_in;
         ne_ff       <= ne_in;
         total_ff    <= total_in;
         rsp_done_ff <= rsp_done_in;
         act_ff      <= act_in;
         lcnt_ff     <= lcnt_in;
      end
      ret_ff       <= ret_in;
      v_ff         <= v_in;
      k_ff         <= k_in;
      nxt_ff       <= nxt_in;
      prv_ff       <= prv_in;
      lvl_ff       <= lvl_in;
      bkt_ff       <= bkt_in;
      ulvl_ff      <= ulvl_in;
      ubkt_ff      <= ubkt_in;
      aux_ff       <= aux_in;
      auxb_ff      <= auxb_in;
      i_ff         <= i_in;
      scan_ff      <= scan_in;
      rsp_mv_ff    <= rsp_mv_in;
      rsp_mk_ff    <= rsp_mk_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_uf_ff    <= rsp_uf_in;
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_done       = rsp_done_ff;
   assign rsp_min_vertex = rsp_mv_ff;
   assign rsp_min_key    = rsp_mk_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_underflow  = rsp_uf_ff;

endmodule

// ===== tb/sv/multilevel_bucket_queue_decrease_key_tb.sv =====
`timescale 1ns / 1ps

module multilevel_bucket_queue_decrease_key_tb;

   localparam int LVLS = 4;
   localparam int NB = 16;
   localparam int NV = 1024;
   localparam int IDLE_LIMIT = 200000;

   typedef struct packed {
      logic [9:0]  vtx;
      logic [31:0] key;
      logic        empty;
      logic        uflow;
   } pq_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = 2'd0;
   logic [9:0]  req_vertex = 10'd0;
   logic [31:0] req_key = 32'd0;
   logic        rsp_done;
   logic [9:0]  rsp_min_vertex;
   logic [31:0] rsp_min_key;
   logic        rsp_is_empty;
   logic        rsp_underflow;

   multilevel_bucket_queue_decrease_key uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_vertex(req_vertex), .req_key(req_key),
      .rsp_done(rsp_done), .rsp_min_vertex(rsp_min_vertex),
      .rsp_min_key(rsp_min_key), .rsp_is_empty(rsp_is_empty),
      .rsp_underflow(rsp_underflow)
   );

   always #4 clock = ~clock;

   // Shadow copy of the queue state.
   logic [31:0] v_key [NV];
   int          v_lvl [NV];
   int          v_bkt [NV];
   int          v_nxt [NV];
   int          v_prv [NV];
   int          b_head [LVLS*NB];
   int          b_tail [LVLS*NB];
   bit          b_used [LVLS*NB];
   int          act_bkt [LVLS];
   int          lvl_cnt [LVLS];
   int          queued;

   pq_result_type pending_results [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   logic [31:0] floor_key = 0;

   function automatic int key_digit(logic [31:0] k, int l);
      return (k >> (4 * (LVLS - 1 - l))) & 4'hF;
   endfunction

   function automatic void bucket_append(int l, int b, int v);
      int s;
      s = l * NB + b;
      if (b_used[s]) begin
         v_nxt[b_tail[s]] = v;
         v_prv[v] = b_tail[s];
      end else begin
         b_head[s] = v;
         b_used[s] = 1'b1;
      end
      b_tail[s] = v;
      v_lvl[v] = l;
      v_bkt[v] = b;
      lvl_cnt[l]++;
   endfunction

   function automatic void bucket_remove(int v);
      int l, s;
      bit h, t;
      l = v_lvl[v];
      s = l * NB + v_bkt[v];
      h = b_head[s] == v;
      t = b_tail[s] == v;
      if (h && t) b_used[s] = 1'b0;
      else if (h) b_head[s] = v_nxt[v];
      else if (t) b_tail[s] = v_prv[v];
      else begin
         v_nxt[v_prv[v]] = v_nxt[v];
         v_prv[v_nxt[v]] = v_prv[v];
      end
      lvl_cnt[l]--;
      v_lvl[v] = LVLS;
   endfunction

   function automatic void place_vertex(int v, logic [31:0] k);
      int d;
      v_key[v] = k;
      for (int i = 0; i + 2 < LVLS; i++) begin
         d = key_digit(k, i);
         if (d != act_bkt[i]) begin
            bucket_append(i, d, v);
            return;
         end
      end
      if (key_digit(k, LVLS-2) != act_bkt[LVLS-2] || key_digit(k, LVLS-1) < act_bkt[LVLS-1])
         bucket_append(LVLS-2, key_digit(k, LVLS-2), v);
      else
         bucket_append(LVLS-1, key_digit(k, LVLS-1), v);
   endfunction

   // Advances the lowest level to a nonempty bucket, refilling it from above.
   function automatic bit refill_lowest();
      int bot, aux, b, n, s, v, d;
      bot = LVLS - 1;
      while (act_bkt[bot] < NB && !b_used[bot*NB + act_bkt[bot]]) act_bkt[bot]++;
      if (act_bkt[bot] < NB) return 1'b1;
      aux = LVLS - 2;
      while (aux >= 0 && lvl_cnt[aux] == 0) aux--;
      if (aux < 0) return 1'b0;
      b = act_bkt[aux];
      if (b >= NB) b = 0;
      for (n = 0; n < NB; n++) begin
         if (b_used[aux*NB + b]) break;
         b = (b + 1) % NB;
      end
      if (n == NB) return 1'b0;
      act_bkt[aux] = b;
      for (int i = aux; i + 1 < LVLS; i++) begin
         s = i * NB + act_bkt[i];
         act_bkt[i+1] = NB;
         while (b_used[s]) begin
            v = b_head[s];
            bucket_remove(v);
            d = key_digit(v_key[v], i + 1);
            bucket_append(i + 1, d, v);
            if (d < act_bkt[i+1]) act_bkt[i+1] = d;
         end
      end
      return act_bkt[bot] < NB;
   endfunction

   function automatic void clear_queue();
      foreach (v_lvl[i]) v_lvl[i] = LVLS;
      foreach (b_used[i]) b_used[i] = 1'b0;
      foreach (act_bkt[i]) begin
         act_bkt[i] = 0;
         lvl_cnt[i] = 0;
      end
      queued = 0;
   endfunction

   function automatic pq_result_type queue_step(mbq_pkg::op_type op, int v, logic [31:0] k);
      pq_result_type r;
      int m;
      r = '0;
      case (op)
         mbq_pkg::OP_INSERT, mbq_pkg::OP_DECREASE: begin
            if (v_lvl[v] < LVLS) bucket_remove(v);
            else queued++;
            place_vertex(v, k);
         end
         mbq_pkg::OP_EXTRACT: begin
            if (queued == 0 || !refill_lowest()) r.uflow = 1'b1;
            else begin
               m = b_head[(LVLS-1)*NB + act_bkt[LVLS-1]];
               bucket_remove(m);
               queued--;
               r.vtx = 10'(m);
               r.key = v_key[m];
            end
         end
         default: clear_queue();
      endcase
      r.empty = queued == 0;
      return r;
   endfunction

   task automatic send_cmd(mbq_pkg::op_type op, logic [9:0] v, logic [31:0] k);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_op <= op;
      req_vertex <= v;
      req_key <= k;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results = {pending_results, queue_step(op, v, k)};
      burst_left--;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_cmd(mbq_pkg::OP_EXTRACT, 10'd0, 32'd0);
      send_cmd(mbq_pkg::OP_INSERT, 10'd0, 32'd0);
      send_cmd(mbq_pkg::OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
      send_cmd(mbq_pkg::OP_INSERT, 10'd5, 32'h0123_4567);
      send_cmd(mbq_pkg::OP_INSERT, 10'd5, 32'h0000_0042);
      send_cmd(mbq_pkg::OP_DECREASE, 10'd1023, 32'h0000_0100);
      send_cmd(mbq_pkg::OP_DECREASE, 10'd77, 32'h0000_0010);
      send_cmd(mbq_pkg::OP_INSERT, 10'd512, 32'hAAAA_5555);
      send_cmd(mbq_pkg::OP_INSERT, 10'd341, 32'h5555_AAAA);
      repeat (7) send_cmd(mbq_pkg::OP_EXTRACT, 10'd0, 32'd0);
      send_cmd(mbq_pkg::OP_INSERT, 10'd9, 32'h8000_0000);
      send_cmd(mbq_pkg::OP_INSERT, 10'd10, 32'h7FFF_FFFF);
      send_cmd(mbq_pkg::OP_CLEAR, 10'd0, 32'd0);
      send_cmd(mbq_pkg::OP_EXTRACT, 10'd0, 32'd0);
      send_cmd(mbq_pkg::OP_INSERT, 10'd9, 32'h0000_0001);
      send_cmd(mbq_pkg::OP_EXTRACT, 10'd0, 32'd0);
      drain_results();
   endtask

   // Shortest-path style traffic: keys never fall below the last minimum.
   task automatic test_monotone_search(int n);
      pq_result_type r;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 40)
            send_cmd(mbq_pkg::OP_INSERT, 10'($urandom_range(0, 1023)),
                     32'(floor_key + $urandom_range(0, (sel < 20) ? 255 : 65535)));
         else if (sel < 60)
            send_cmd(mbq_pkg::OP_DECREASE, 10'($urandom_range(0, 1023)),
                     32'(floor_key + $urandom_range(0, 4095)));
         else if (sel < 99) begin
            send_cmd(mbq_pkg::OP_EXTRACT, 10'd0, 32'd0);
            r = pending_results[$];
            if (!r.uflow) floor_key = r.key;
         end else begin
            send_cmd(mbq_pkg::OP_CLEAR, 10'd0, 32'd0);
            floor_key = 0;
         end
      end
      drain_results();
   endtask

   task automatic test_random_noise(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) send_cmd(mbq_pkg::OP_INSERT, 10'($urandom), 32'($urandom));
         else if (sel < 65) send_cmd(mbq_pkg::OP_DECREASE, 10'($urandom), 32'($urandom));
         else if (sel < 98) send_cmd(mbq_pkg::OP_EXTRACT, 10'($urandom), 32'($urandom));
         else send_cmd(mbq_pkg::OP_CLEAR, 10'($urandom), 32'($urandom));
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_done) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            pq_result_type e;
            e = pending_results[0];
            pending_results.delete(0);
            if (e.vtx !== rsp_min_vertex || e.key !== rsp_min_key ||
                e.empty !== rsp_is_empty || e.uflow !== rsp_underflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp v=%0d k=%h e=%b u=%b got v=%0d k=%h e=%b u=%b",
                           $realtime, e.vtx, e.key, e.empty, e.uflow, rsp_min_vertex,
                           rsp_min_key, rsp_is_empty, rsp_underflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      clear_queue();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_monotone_search(900);
      test_random_noise(300);
      test_monotone_search(450);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
